FILE: design/stencil_euler_tendency_core_defines.svh
// assertion macros shared by the stencil tendency core
// no dependencies; include once per file that asserts
`ifndef STENCIL_EULER_TENDENCY_CORE_DEFINES_SVH
`define STENCIL_EULER_TENDENCY_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked while out of reset
`define STET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stet assertion failed");
// property checked on every edge, reset included
`define STET_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("stet assertion failed");
`else
`define STET_ASSERT(lbl, prop)
`define STET_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/stet_pkg.sv
// types, constants and arithmetic helpers of the stencil tendency core
// no dependencies
package stet_pkg;

  localparam int ACC_WIDTH     = 48;
  localparam int MAX_NEIGHBORS = 32;
  localparam int FRAC_BITS     = 16;

  // product after the fraction shift, widest accumulate sum, result sum
  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam int RW = PW + 3;
  localparam int XW = 65;

  localparam int NUM_SUMS = 11;
  localparam int SUM_IW   = $clog2(NUM_SUMS);
  localparam int NUM_CFG  = 6;
  localparam int CFG_IW   = 3;
  localparam int STEP_W   = 5;
  localparam int CNT_W    = $clog2(MAX_NEIGHBORS + 1);
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  localparam logic KIND_NBR   = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_CP    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_THB   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_VISC  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BUOY  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_GAS   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_EXG   = 3'd5;

  localparam logic [SUM_IW-1:0] S_UX  = 4'd0;
  localparam logic [SUM_IW-1:0] S_WX  = 4'd1;
  localparam logic [SUM_IW-1:0] S_THX = 4'd2;
  localparam logic [SUM_IW-1:0] S_PIX = 4'd3;
  localparam logic [SUM_IW-1:0] S_UZ  = 4'd4;
  localparam logic [SUM_IW-1:0] S_WZ  = 4'd5;
  localparam logic [SUM_IW-1:0] S_THZ = 4'd6;
  localparam logic [SUM_IW-1:0] S_PIZ = 4'd7;
  localparam logic [SUM_IW-1:0] S_LU  = 4'd8;
  localparam logic [SUM_IW-1:0] S_LW  = 4'd9;
  localparam logic [SUM_IW-1:0] S_LTH = 4'd10;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] val_u;
    logic signed [31:0] val_w;
    logic signed [31:0] val_theta;
    logic signed [31:0] val_pi;
    logic signed [31:0] weight_dx;
    logic signed [31:0] weight_dz;
    logic signed [31:0] weight_lap;
    logic signed [31:0] pi_background;
  } item_t;

  typedef struct packed {
    logic signed [31:0] rhs_u;
    logic signed [31:0] rhs_w;
    logic signed [31:0] rhs_theta;
    logic signed [31:0] rhs_pi;
    logic               saturated;
  } result_t;

  // handshake between front queue and back engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_out_t;

  typedef enum logic [3:0] {
    A_WDX, A_WDZ, A_WLAP, A_CP, A_GAS, A_BUOY, A_U, A_W, A_PRES, A_VISC, A_GFAC
  } opa_t;

  typedef enum logic [3:0] {
    B_U, B_W, B_TH, B_PI, B_T1, B_T2, B_SUM, B_EZ, B_DIV
  } opb_t;

  typedef enum logic [2:0] {D_NONE, D_ACC, D_PRES, D_GFAC, D_RES} dst_t;
  typedef enum logic [1:0] {P_NONE, P_HOLD, P_DIV, P_EZ} prep_t;

  typedef struct packed {
    opa_t              a;
    opb_t              b;
    dst_t              dst;
    prep_t             prep;
    logic [SUM_IW-1:0] idx;
    logic [SUM_IW-1:0] rd;
    logic              neg;
    logic              last;
  } uop_t;

  // saturate to 32 bits, msb of the result is the clip flag
  function automatic logic [32:0] sat32(input logic signed [XW-1:0] x);
    logic [32:0] r;
    if (x > 65'sh0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -65'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  function automatic logic signed [XW-1:0] ext32(input logic signed [31:0] x);
    return {{(XW-32){x[31]}}, x};
  endfunction

  // one step of the micro program, neighbor or close
  function automatic uop_t uop_decode(input logic kind, input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{a: A_U, b: B_U, dst: D_NONE, prep: P_NONE, idx: '0, rd: '0, neg: 1'b0,
          last: 1'b0};
    if (kind == KIND_NBR) begin
      u.a = (step < 5'd4) ? A_WDX : ((step < 5'd8) ? A_WDZ : A_WLAP);
      unique case (step[1:0])
        2'd0:    u.b = B_U;
        2'd1:    u.b = B_W;
        2'd2:    u.b = B_TH;
        default: u.b = B_PI;
      endcase
      u.dst  = D_ACC;
      u.idx  = step[SUM_IW-1:0];
      u.last = (step == 5'(NUM_SUMS - 1));
    end else begin
      u.dst = D_RES;
      unique case (step)
        5'd0: begin
          u.a = A_CP; u.b = B_T1; u.dst = D_PRES; u.prep = P_HOLD; u.rd = S_UX;
        end
        5'd1: begin
          u.a = A_GAS; u.b = B_T2; u.dst = D_GFAC; u.prep = P_DIV; u.rd = S_WZ;
        end
        5'd2: begin
          u.a = A_BUOY; u.b = B_TH; u.idx = 4'd1; u.prep = P_EZ; u.rd = S_PIZ;
        end
        5'd3:  begin u.a = A_U;    u.b = B_SUM; u.rd = S_UX;  u.idx = 4'd0; u.neg = 1'b1; end
        5'd4:  begin u.a = A_W;    u.b = B_SUM; u.rd = S_UZ;  u.idx = 4'd0; u.neg = 1'b1; end
        5'd5:  begin u.a = A_PRES; u.b = B_SUM; u.rd = S_PIX; u.idx = 4'd0; u.neg = 1'b1; end
        5'd6:  begin u.a = A_VISC; u.b = B_SUM; u.rd = S_LU;  u.idx = 4'd0; end
        5'd7:  begin u.a = A_U;    u.b = B_SUM; u.rd = S_WX;  u.idx = 4'd1; u.neg = 1'b1; end
        5'd8:  begin u.a = A_W;    u.b = B_SUM; u.rd = S_WZ;  u.idx = 4'd1; u.neg = 1'b1; end
        5'd9:  begin u.a = A_PRES; u.b = B_SUM; u.rd = S_PIZ; u.idx = 4'd1; u.neg = 1'b1; end
        5'd10: begin u.a = A_VISC; u.b = B_SUM; u.rd = S_LW;  u.idx = 4'd1; end
        5'd11: begin u.a = A_U;    u.b = B_SUM; u.rd = S_THX; u.idx = 4'd2; u.neg = 1'b1; end
        5'd12: begin u.a = A_W;    u.b = B_SUM; u.rd = S_THZ; u.idx = 4'd2; u.neg = 1'b1; end
        5'd13: begin u.a = A_VISC; u.b = B_SUM; u.rd = S_LTH; u.idx = 4'd2; end
        5'd14: begin u.a = A_U;    u.b = B_SUM; u.rd = S_PIX; u.idx = 4'd3; u.neg = 1'b1; end
        5'd15: begin u.a = A_W;    u.b = B_EZ;  u.idx = 4'd3; u.neg = 1'b1; end
        5'd16: begin
          u.a = A_GFAC; u.b = B_DIV; u.idx = 4'd3; u.neg = 1'b1; u.last = 1'b1;
        end
        default: begin u.dst = D_NONE; u.last = 1'b1; end
      endcase
    end
    return u;
  endfunction

endpackage

FILE: design/stencil_euler_tendency_core.sv
// top level of the stencil tendency core: front queue and back engine
// depends on stet_pkg, stet_front, stet_back
//
// usage
//   input channel (push/full): one item per accepted push. kind 0 is a
//   neighbor term (values plus dx, dz and Laplacian weights), kind 1 closes
//   the node with its own state and background Exner value.
//   result channel (empty/pop): one result per close item, held on the
//   out_ ports while empty is low, taken when pop is high.
//   cfg port: cfg_we writes cfg_wdata into register cfg_index at once.
// timing
//   all products go through one 32x32 multiplier, one product per cycle while the engine runs.
//   a neighbor item takes 11 products, a close item 17 products, and a
//   neighbor beyond the limit is dropped without any products.
//   a 2-entry front queue lets items arrive while the engine works.
// reset and stall
//   synchronous reset clears sums, counters, flags and config registers to zero.
//   when the receiver stalls, the result waits in the output register; the
//   engine keeps taking neighbor items and blocks only at the next close.
module stencil_euler_tendency_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_kind,
  input  logic signed [31:0]           in_val_u,
  input  logic signed [31:0]           in_val_w,
  input  logic signed [31:0]           in_val_theta,
  input  logic signed [31:0]           in_val_pi,
  input  logic signed [31:0]           in_weight_dx,
  input  logic signed [31:0]           in_weight_dz,
  input  logic signed [31:0]           in_weight_lap,
  input  logic signed [31:0]           in_pi_background,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [31:0]           out_rhs_u,
  output logic signed [31:0]           out_rhs_w,
  output logic signed [31:0]           out_rhs_theta,
  output logic signed [31:0]           out_rhs_pi,
  output logic                         out_saturated,
  input  logic                         cfg_we,
  input  logic [stet_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                  cfg_wdata
);
  import stet_pkg::*;

  item_t   in_item;
  fq_out_t fq;
  logic    fq_pop;
  result_t res;

  // pack input fields
  assign in_item = '{kind: in_kind, val_u: in_val_u, val_w: in_val_w,
                     val_theta: in_val_theta, val_pi: in_val_pi,
                     weight_dx: in_weight_dx, weight_dz: in_weight_dz,
                     weight_lap: in_weight_lap, pi_background: in_pi_background};

  stet_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .fq      (fq),
    .fq_pop  (fq_pop)
  );

  stet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq        (fq),
    .fq_pop    (fq_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  // unpack result
  assign out_rhs_u     = res.rhs_u;
  assign out_rhs_w     = res.rhs_w;
  assign out_rhs_theta = res.rhs_theta;
  assign out_rhs_pi    = res.rhs_pi;
  assign out_saturated = res.saturated;

endmodule

FILE: design/stet_front.sv
// front queue: accepts items and holds them for the engine
// depends on stet_pkg
module stet_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  stet_pkg::item_t    in_item,
  output stet_pkg::fq_out_t  fq,
  input  logic               fq_pop
);
  import stet_pkg::*;

  item_t            mem_r [FQ_DEPTH];
  logic [FQ_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = fq_pop && (cnt_r != '0);
  assign fq.valid = (cnt_r != '0);
  assign fq.item  = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= in_item;
  end

endmodule

FILE: design/stet_back.sv
// back engine: micro-sequenced multiply-accumulate over one shared multiplier
// depends on stet_pkg and the assertion macro header
`include "stencil_euler_tendency_core_defines.svh"
module stet_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stet_pkg::fq_out_t             fq,
  output logic                          fq_pop,
  input  logic                          cfg_we,
  input  logic [stet_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          pop,
  output logic                          empty,
  output stet_pkg::result_t             res
);
  import stet_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  item_t                      item_r;
  logic [STEP_W-1:0]          step_r;
  logic signed [31:0]         cfg_r [NUM_CFG];
  logic signed [ACC_WIDTH-1:0] sums_r [NUM_SUMS];
  logic signed [RW-1:0]       racc_r [4];
  logic [CNT_W-1:0]           cnt_r;
  logic                       clip_seen_r, close_clip_r;
  logic signed [31:0]         pres_r, gfac_r, hold_r, div_r, ez_r;
  logic signed [63:0]         prod_r;
  logic                       pvalid_r, pneg_r;
  dst_t                       pdst_r;
  logic [SUM_IW-1:0]          pidx_r;
  logic                       out_valid_r;
  result_t                    out_r;

  uop_t                       uop;
  logic                       issuing, accept, drop, emit_load;
  logic signed [31:0]         op_a, op_b;
  logic [32:0]                t1, t2, rd_sat, div_s, ez_s, pres_s, gfac_s;
  logic [32:0]                r_s [4];
  logic [SUM_IW-1:0]          rd_addr;
  logic signed [PW-1:0]       term;
  logic signed [SW-1:0]       acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_new;
  logic                       acc_clip;
  logic signed [RW-1:0]       term_r;
  logic                       issue_clip;

  // control decode
  assign uop       = uop_decode(item_r.kind, step_r);
  assign issuing   = (state_r == ST_RUN);
  assign accept    = (state_r == ST_IDLE) && fq.valid;
  assign drop      = accept && (fq.item.kind == KIND_NBR) &&
                     (cnt_r >= CNT_W'(MAX_NEIGHBORS));
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || pop);
  assign fq_pop    = accept;
  assign empty     = !out_valid_r;
  assign res       = out_r;

  // sum read port and close-time preparation values
  always_comb begin
    rd_addr = (pvalid_r && pdst_r == D_ACC) ? pidx_r : uop.rd;
    rd_sat  = sat32({{(XW-ACC_WIDTH){sums_r[rd_addr][ACC_WIDTH-1]}}, sums_r[rd_addr]});
    t1      = sat32(ext32(cfg_r[CFG_THB]) + ext32(item_r.val_theta));
    t2      = sat32(ext32(item_r.pi_background) + ext32(item_r.val_pi));
    div_s   = sat32(ext32(hold_r) + ext32(rd_sat[31:0]));
    ez_s    = sat32(ext32(cfg_r[CFG_EXG]) + ext32(rd_sat[31:0]));
  end

  // operand selection
  always_comb begin
    unique case (uop.a)
      A_WDX:   op_a = item_r.weight_dx;
      A_WDZ:   op_a = item_r.weight_dz;
      A_WLAP:  op_a = item_r.weight_lap;
      A_CP:    op_a = cfg_r[CFG_CP];
      A_GAS:   op_a = cfg_r[CFG_GAS];
      A_BUOY:  op_a = cfg_r[CFG_BUOY];
      A_U:     op_a = item_r.val_u;
      A_W:     op_a = item_r.val_w;
      A_PRES:  op_a = pres_r;
      A_VISC:  op_a = cfg_r[CFG_VISC];
      A_GFAC:  op_a = gfac_r;
      default: op_a = '0;
    endcase
    unique case (uop.b)
      B_U:     op_b = item_r.val_u;
      B_W:     op_b = item_r.val_w;
      B_TH:    op_b = item_r.val_theta;
      B_PI:    op_b = item_r.val_pi;
      B_T1:    op_b = t1[31:0];
      B_T2:    op_b = t2[31:0];
      B_SUM:   op_b = rd_sat[31:0];
      B_EZ:    op_b = ez_r;
      B_DIV:   op_b = div_r;
      default: op_b = '0;
    endcase
  end

  // clips seen by the issuing step
  always_comb begin
    issue_clip = 1'b0;
    if (issuing && item_r.kind == KIND_CLOSE) begin
      if (uop.b == B_SUM || uop.prep != P_NONE) issue_clip = rd_sat[32];
      if (uop.b == B_T1) issue_clip = issue_clip | t1[32];
      if (uop.b == B_T2) issue_clip = issue_clip | t2[32];
      if (uop.prep == P_DIV) issue_clip = issue_clip | div_s[32];
      if (uop.prep == P_EZ) issue_clip = issue_clip | ez_s[32];
    end
  end

  // apply stage arithmetic
  always_comb begin
    term     = prod_r[63:FRAC_BITS];
    acc_sum  = {{(SW-ACC_WIDTH){sums_r[pidx_r][ACC_WIDTH-1]}}, sums_r[pidx_r]} +
               {{(SW-PW){term[PW-1]}}, term};
    acc_clip = 1'b1;
    if (acc_sum > $signed({{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}}))
      acc_new = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    else if (acc_sum < $signed({{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}}))
      acc_new = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    else begin
      acc_new  = acc_sum[ACC_WIDTH-1:0];
      acc_clip = 1'b0;
    end
    pres_s = sat32({{(XW-PW){term[PW-1]}}, term});
    gfac_s = pres_s;
    term_r = pneg_r ? -{{(RW-PW){term[PW-1]}}, term} : {{(RW-PW){term[PW-1]}}, term};
    for (int k = 0; k < 4; k++)
      r_s[k] = sat32({{(XW-RW){racc_r[k][RW-1]}}, racc_r[k]});
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && !drop) state_nxt = ST_RUN;
      ST_RUN:   if (uop.last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = (item_r.kind == KIND_CLOSE) ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (emit_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      cnt_r        <= '0;
      clip_seen_r  <= 1'b0;
      close_clip_r <= 1'b0;
      pvalid_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < NUM_CFG; k++) cfg_r[k] <= '0;
      for (int k = 0; k < NUM_SUMS; k++) sums_r[k] <= '0;
    end else begin
      state_r  <= state_nxt;
      pvalid_r <= issuing && (uop.dst != D_NONE);
      if (cfg_we && cfg_index < CFG_IW'(NUM_CFG))
        cfg_r[cfg_index] <= cfg_wdata;
      if (issuing) step_r <= step_r + 1'b1;
      if (accept) begin
        step_r <= '0;
        if (drop) clip_seen_r <= 1'b1;
        else if (fq.item.kind == KIND_NBR) cnt_r <= cnt_r + 1'b1;
        else close_clip_r <= 1'b0;
      end
      // close-time clips from the issue and apply stages
      if (issue_clip ||
          (pvalid_r && (pdst_r == D_PRES || pdst_r == D_GFAC) && pres_s[32]))
        close_clip_r <= 1'b1;
      if (pvalid_r && pdst_r == D_ACC) begin
        sums_r[pidx_r] <= acc_new;
        if (acc_clip) clip_seen_r <= 1'b1;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        clip_seen_r <= 1'b0;
        for (int k = 0; k < NUM_SUMS; k++) sums_r[k] <= '0;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= fq.item;
    if (accept && fq.item.kind == KIND_CLOSE)
      for (int k = 0; k < 4; k++) racc_r[k] <= '0;
    if (issuing) begin
      prod_r <= 64'(op_a) * 64'(op_b);
      pdst_r <= uop.dst;
      pidx_r <= uop.idx;
      pneg_r <= uop.neg;
      if (uop.prep == P_HOLD) hold_r <= rd_sat[31:0];
      if (uop.prep == P_DIV) div_r <= div_s[31:0];
      if (uop.prep == P_EZ) ez_r <= ez_s[31:0];
    end
    if (pvalid_r && pdst_r == D_PRES) pres_r <= pres_s[31:0];
    if (pvalid_r && pdst_r == D_GFAC) gfac_r <= gfac_s[31:0];
    if (pvalid_r && pdst_r == D_RES)
      racc_r[pidx_r[1:0]] <= racc_r[pidx_r[1:0]] + term_r;
    if (emit_load) begin
      out_r.rhs_u     <= r_s[0][31:0];
      out_r.rhs_w     <= r_s[1][31:0];
      out_r.rhs_theta <= r_s[2][31:0];
      out_r.rhs_pi    <= r_s[3][31:0];
      out_r.saturated <= clip_seen_r | close_clip_r |
                         r_s[0][32] | r_s[1][32] | r_s[2][32] | r_s[3][32];
    end
  end

  // checks
  `STET_ASSERT(a_cnt_limit, cnt_r <= CNT_W'(MAX_NEIGHBORS))
  `STET_ASSERT(a_emit_drained, state_r == ST_EMIT |-> !pvalid_r)
  `STET_ASSERT(a_emit_clears, emit_load |=> (cnt_r == '0 && !clip_seen_r && out_valid_r))

endmodule
